### rtl/http_chunked_decoder_assert.svh
// assertion macros for the chunked decoder
// HCD_ASSERT checks a property on the rising edge of clk outside reset
// HCD_NEVER checks that an expression is never true
`ifndef HTTP_CHUNKED_DECODER_ASSERT_SVH
`define HTTP_CHUNKED_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
`define HCD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HCD_NEVER(lbl, expr, msg) `HCD_ASSERT(lbl, !(expr), msg)
`else
`define HCD_ASSERT(lbl, prop, msg)
`define HCD_NEVER(lbl, expr, msg)
`endif
`endif

### rtl/hcd_pkg.sv
package hcd_pkg;

    // default width of the chunk length
    localparam int LEN_BITS_DEF = 32;

    // result codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_NO_DIGITS = 3'd1;
    localparam logic [2:0] ERR_TRUNCATED = 3'd2;
    localparam logic [2:0] ERR_NO_CRLF   = 3'd3;
    localparam logic [2:0] ERR_OVERFLOW  = 3'd4;

    // one encoded byte as held in the input register
    typedef struct packed {
        logic       last;
        logic [7:0] data;
    } hcd_item_t;

    // result of one processed byte
    typedef struct packed {
        logic       valid;
        logic [7:0] out_byte;
        logic       payload_valid;
        logic       finished;
        logic [2:0] error_code;
    } hcd_result_t;

    // true for 0-9, A-F, a-f
    function automatic logic hcd_is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
    endfunction

    // value of a hex digit, zero for anything else
    function automatic logic [3:0] hcd_hex_val(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = c - 8'h30;
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            v = c - 8'h37;
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            v = c - 8'h57;
        end
        return v[3:0];
    endfunction

    // space, HT, LF, VT, FF, CR
    function automatic logic hcd_is_space(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

endpackage

### rtl/hcd_in_reg.sv
module hcd_in_reg
    import hcd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_axis_tvalid,
    output logic      s_axis_tready,
    input  logic [7:0] s_axis_tdata,  // in_byte[7:0]
    input  logic      s_axis_tlast,   // end_of_input
    input  logic      take,
    output logic      item_valid,
    output hcd_item_t item
);

    logic      valid_reg;
    logic      valid_next;
    hcd_item_t item_reg;
    logic      accept;

    // room when empty or when the held request moves on this cycle
    assign s_axis_tready = !valid_reg || take;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.data <= s_axis_tdata;
            item_reg.last <= s_axis_tlast;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

### rtl/hcd_core.sv
module hcd_core
    import hcd_pkg::*;
#(
    parameter int LEN_BITS = LEN_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  hcd_item_t   item,
    output hcd_result_t result
);

    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_X_LO = 8'h78;
    localparam logic [7:0] CH_X_UP = 8'h58;
    localparam logic [LEN_BITS-1:0] LEN_ONE = {{(LEN_BITS-1){1'b0}}, 1'b1};

    typedef enum logic [2:0] {
        PH_WS, PH_ZERO, PH_DIGITS, PH_REST, PH_OVF, PH_DATA, PH_TRAIL_CR, PH_TRAIL_LF
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [LEN_BITS-1:0] len_reg, len_next;
    logic [LEN_BITS-1:0] rem_reg, rem_next;
    logic                digit_reg, digit_next;
    logic                cr_reg, cr_next;
    logic                done_reg, done_next;

    logic       [7:0] c;
    logic             hex_ok;
    logic       [3:0] d;
    logic             len_full;
    logic             fin;
    logic       [2:0] fin_code;

    assign c        = item.data;
    assign hex_ok   = hcd_is_hex(c);
    assign d        = hcd_hex_val(c);
    assign len_full = (len_reg[LEN_BITS-1 -: 4] != 4'h0);

    // per-byte decode step
    always_comb
    begin
        phase_next = phase_reg;
        len_next   = len_reg;
        rem_next   = rem_reg;
        digit_next = digit_reg;
        cr_next    = cr_reg;
        done_next  = done_reg;
        fin        = 1'b0;
        fin_code   = ERR_NONE;
        result     = '0;

        if (fire && !done_reg)
        begin
            unique case (phase_reg)
                PH_DATA:
                begin
                    if (item.last)
                    begin
                        fin      = 1'b1;
                        fin_code = ERR_TRUNCATED;
                    end
                    else
                    begin
                        rem_next = rem_reg - LEN_ONE;
                        if (rem_reg == LEN_ONE)
                        begin
                            phase_next = PH_TRAIL_CR;
                        end
                        result.valid         = 1'b1;
                        result.out_byte      = c;
                        result.payload_valid = 1'b1;
                    end
                end
                PH_TRAIL_CR:
                begin
                    if (item.last)
                    begin
                        fin      = 1'b1;
                        fin_code = ERR_TRUNCATED;
                    end
                    else if (c != CH_CR)
                    begin
                        fin      = 1'b1;
                        fin_code = ERR_NO_CRLF;
                    end
                    else
                    begin
                        phase_next = PH_TRAIL_LF;
                    end
                end
                PH_TRAIL_LF:
                begin
                    if (c != CH_LF)
                    begin
                        fin      = 1'b1;
                        fin_code = ERR_NO_CRLF;
                    end
                    else
                    begin
                        phase_next = PH_WS;
                        len_next   = '0;
                        digit_next = 1'b0;
                        cr_next    = 1'b0;
                        if (item.last)
                        begin
                            fin      = 1'b1;
                            fin_code = ERR_NONE;
                        end
                    end
                end
                default:
                begin
                    // size line
                    if (c == CH_LF && cr_reg)
                    begin
                        cr_next    = 1'b0;
                        phase_next = PH_WS;
                        if (phase_reg == PH_OVF)
                        begin
                            fin      = 1'b1;
                            fin_code = ERR_OVERFLOW;
                        end
                        else if (!digit_reg)
                        begin
                            fin      = 1'b1;
                            fin_code = ERR_NO_DIGITS;
                        end
                        else
                        begin
                            digit_next = 1'b0;
                            if (len_reg == '0)
                            begin
                                fin      = 1'b1;
                                fin_code = ERR_NONE;
                            end
                            else if (item.last)
                            begin
                                fin      = 1'b1;
                                fin_code = ERR_TRUNCATED;
                            end
                            else
                            begin
                                rem_next   = len_reg;
                                phase_next = PH_DATA;
                            end
                        end
                    end
                    else
                    begin
                        cr_next = (c == CH_CR);
                        unique case (phase_reg)
                            PH_WS:
                            begin
                                if (c == CH_ZERO)
                                begin
                                    digit_next = 1'b1;
                                    len_next   = '0;
                                    phase_next = PH_ZERO;
                                end
                                else if (hex_ok)
                                begin
                                    digit_next = 1'b1;
                                    len_next   = {{(LEN_BITS-4){1'b0}}, d};
                                    phase_next = PH_DIGITS;
                                end
                                else if (!hcd_is_space(c))
                                begin
                                    phase_next = PH_REST;
                                end
                            end
                            PH_ZERO, PH_DIGITS:
                            begin
                                if (phase_reg == PH_ZERO && (c == CH_X_LO || c == CH_X_UP))
                                begin
                                    phase_next = PH_DIGITS;
                                end
                                else if (hex_ok)
                                begin
                                    // append a digit unless the top nibble is in use
                                    if (len_full)
                                    begin
                                        phase_next = PH_OVF;
                                    end
                                    else
                                    begin
                                        len_next   = {len_reg[LEN_BITS-5:0], d};
                                        phase_next = PH_DIGITS;
                                    end
                                end
                                else
                                begin
                                    phase_next = PH_REST;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                        if (item.last)
                        begin
                            fin      = 1'b1;
                            fin_code = ERR_TRUNCATED;
                        end
                    end
                end
            endcase

            // end of decoding
            if (fin)
            begin
                done_next         = 1'b1;
                result            = '0;
                result.valid      = 1'b1;
                result.finished   = 1'b1;
                result.error_code = fin_code;
            end
        end
    end

    // decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_WS;
            len_reg   <= '0;
            rem_reg   <= '0;
            digit_reg <= 1'b0;
            cr_reg    <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            rem_reg   <= rem_next;
            digit_reg <= digit_next;
            cr_reg    <= cr_next;
            done_reg  <= done_next;
        end
    end

endmodule

### rtl/http_chunked_decoder.sv
// chunked body decoder, one encoded byte per request
// a result is decoded combinationally from the byte in the input register and
// registered in the output register; throughput: one byte per cycle unless
// the master side holds off m_axis_tready
// reset: asynchronous active-low rst_n returns to the start of a size line and
// empties both registers
`include "http_chunked_decoder_assert.svh"

module http_chunked_decoder
    import hcd_pkg::*;
#(
    parameter int LEN_BITS = LEN_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // in_byte[7:0]
    input  logic        s_axis_tlast,   // end_of_input
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // out_byte[7:0], error_code[10:8], zero[15:11]
    output logic        m_axis_tuser,   // payload_valid
    output logic        m_axis_tlast    // finished
);

    hcd_item_t   item;
    logic        item_valid;
    logic        fire;
    hcd_result_t result;

    logic        out_valid_reg, out_valid_next;
    hcd_result_t out_reg;

    // held byte moves on when the output register is free or draining
    assign fire = item_valid && (!out_valid_reg || m_axis_tready);

    hcd_in_reg u_in_reg (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .take          (fire),
        .item_valid    (item_valid),
        .item          (item)
    );

    hcd_core #(
        .LEN_BITS (LEN_BITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item),
        .result (result)
    );

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire && result.valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && result.valid)
        begin
            out_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b00000, out_reg.error_code, out_reg.out_byte};
    assign m_axis_tuser  = out_reg.payload_valid;
    assign m_axis_tlast  = out_reg.finished;

    // checks
    `HCD_NEVER(a_payload_not_final, m_axis_tvalid && m_axis_tuser && m_axis_tlast, "payload on final result")
    `HCD_ASSERT(a_code_only_final, m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[10:8] == ERR_NONE, "error code on non-final result")
    `HCD_ASSERT(a_byte_only_payload, m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[7:0] == 8'h00, "data byte without payload flag")
    `HCD_ASSERT(a_silent_after_final, m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid, "result after final result")

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import hcd_pkg::*;

    localparam int LB           = LEN_BITS_DEF;
    localparam int STALL_CYCLES = 300;
    localparam int WATCHDOG     = 3000;
    localparam int RANDOM_BYTES = 1420;
    localparam int SETTLE       = 8;

    localparam logic [7:0] CR = 8'h0D;
    localparam logic [7:0] LF = 8'h0A;

    // candidate bytes, one per byte lane
    localparam logic [47:0] BLANKS       = {8'h20, 8'h09, LF, 8'h0B, 8'h0C, CR};
    localparam logic [55:0] TAIL_STARTS  = {";", " ", 8'h09, "+", "z", CR, LF};
    localparam logic [47:0] NODIG_STARTS = {"-", "+", ";", "g", "x", "Z"};

    // decoder phases as the predictor tracks them
    typedef enum logic [2:0] {
        P_SPACE, P_ZERO, P_DIGITS, P_REST, P_OVF, P_DATA, P_TRAIL_CR, P_TRAIL_LF
    } dec_phase_t;

    // how an accepted request is checked
    typedef enum logic [1:0] {CHK_PRED, CHK_QUIET, CHK_DATA} chk_t;

    // what follows the data of a chunk
    typedef enum logic [1:0] {TR_PLAIN, TR_LAST, TR_CUT, TR_BAD} trail_t;

    // the way the stream is closed in this run
    typedef enum logic [3:0] {
        END_ZERO, END_AFTER_CRLF, END_CUT_LINE, END_CUT_SIZE, END_CUT_DATA,
        END_CUT_TRAIL, END_BAD_TRAIL, END_NO_DIGITS, END_OVERFLOW
    } close_t;

    typedef struct packed {
        logic [7:0] data;
        logic       payload;
        logic       done;
        logic [2:0] code;
    } decoded_t;

    typedef struct packed {
        logic [7:0] b;
        chk_t       kind;
        logic [7:0] want;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    // opening of the stream: padded size line with 0X prefix, data extremes,
    // lone LF and lone CR around the digits, a sign after them
    row_t intro_rows [24] = '{
        '{" ",   CHK_PRED,  8'h00},
        '{8'h09, CHK_PRED,  8'h00},
        '{"0",   CHK_PRED,  8'h00},
        '{"X",   CHK_PRED,  8'h00},
        '{"2",   CHK_PRED,  8'h00},
        '{";",   CHK_PRED,  8'h00},
        '{CR,    CHK_QUIET, 8'h00},
        '{LF,    CHK_QUIET, 8'h00},
        '{8'h00, CHK_DATA,  8'h00},
        '{8'hFF, CHK_DATA,  8'hFF},
        '{CR,    CHK_QUIET, 8'h00},
        '{LF,    CHK_QUIET, 8'h00},
        '{LF,    CHK_PRED,  8'h00},
        '{CR,    CHK_PRED,  8'h00},
        '{"3",   CHK_PRED,  8'h00},
        '{CR,    CHK_PRED,  8'h00},
        '{"-",   CHK_PRED,  8'h00},
        '{CR,    CHK_QUIET, 8'h00},
        '{LF,    CHK_QUIET, 8'h00},
        '{CR,    CHK_DATA,  CR},
        '{LF,    CHK_DATA,  LF},
        '{"0",   CHK_DATA,  "0"},
        '{CR,    CHK_QUIET, 8'h00},
        '{LF,    CHK_QUIET, 8'h00}
    };

    // predictor state
    dec_phase_t    dec_phase = P_SPACE;
    logic [LB-1:0] dec_len = '0;
    logic [LB-1:0] dec_left = '0;
    bit            dec_digit = 1'b0;
    bit            dec_cr = 1'b0;
    bit            dec_done = 1'b0;
    logic [2:0]    last_code = ERR_NONE;

    decoded_t   result_q [$];
    logic [7:0] pend [$];

    // request in flight on the slave side
    chk_t       row_kind = CHK_PRED;
    logic [7:0] row_want = 8'h00;

    bit stall_req = 1'b0;
    bit stall_done = 1'b0;
    bit press = 1'b0;
    bit calm = 1'b0;

    int errors = 0;
    int n_sent = 0;
    int n_bytes = 0;
    int n_chunks = 0;
    int n_payload = 0;
    int idle_cycles = 0;

    http_chunked_decoder #(.LEN_BITS(LB)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    // hex digit value, 16 for anything else
    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        if (c >= "0" && c <= "9") return 5'(c - "0");
        if (c >= "A" && c <= "F") return 5'(c - "A" + 8'd10);
        if (c >= "a" && c <= "f") return 5'(c - "a" + 8'd10);
        return 5'd16;
    endfunction

    function automatic bit close_stream(input logic [2:0] code, output decoded_t r);
        dec_done = 1'b1;
        last_code = code;
        r = '{8'h00, 1'b0, 1'b1, code};
        return 1'b1;
    endfunction

    // shift one more digit into the length unless it would not fit
    function automatic void feed_nibble(input logic [3:0] d);
        if (dec_len[LB-1 -: 4] != 4'h0)
        begin
            dec_phase = P_OVF;
        end
        else
        begin
            dec_len = {dec_len[LB-5:0], d};
            dec_phase = P_DIGITS;
        end
    endfunction

    // expected outcome of one encoded byte, 1 when it yields a result
    function automatic bit decode_byte(input logic [7:0] c, input logic last,
                                       output decoded_t r);
        logic [4:0] d;
        dec_phase_t ended;
        r = '0;
        d = nibble_of(c);
        if (dec_done) return 1'b0;
        case (dec_phase)
            P_DATA:
            begin
                if (last) return close_stream(ERR_TRUNCATED, r);
                dec_left = dec_left - 1'b1;
                if (dec_left == '0) dec_phase = P_TRAIL_CR;
                r = '{c, 1'b1, 1'b0, ERR_NONE};
                return 1'b1;
            end
            P_TRAIL_CR:
            begin
                if (last) return close_stream(ERR_TRUNCATED, r);
                if (c != CR) return close_stream(ERR_NO_CRLF, r);
                dec_phase = P_TRAIL_LF;
                return 1'b0;
            end
            P_TRAIL_LF:
            begin
                if (c != LF) return close_stream(ERR_NO_CRLF, r);
                dec_phase = P_SPACE;
                dec_len = '0;
                dec_digit = 1'b0;
                dec_cr = 1'b0;
                if (last) return close_stream(ERR_NONE, r);
                return 1'b0;
            end
            default: ;
        endcase

        // CR LF closes the size line
        if (c == LF && dec_cr)
        begin
            ended = dec_phase;
            dec_cr = 1'b0;
            dec_phase = P_SPACE;
            if (ended == P_OVF) return close_stream(ERR_OVERFLOW, r);
            if (!dec_digit) return close_stream(ERR_NO_DIGITS, r);
            dec_digit = 1'b0;
            if (dec_len == '0) return close_stream(ERR_NONE, r);
            if (last) return close_stream(ERR_TRUNCATED, r);
            dec_left = dec_len;
            dec_phase = P_DATA;
            n_chunks++;
            return 1'b0;
        end

        // any other size line byte
        dec_cr = (c == CR);
        case (dec_phase)
            P_SPACE:
            begin
                if (c == "0")
                begin
                    dec_digit = 1'b1;
                    dec_len = '0;
                    dec_phase = P_ZERO;
                end
                else if (d < 16)
                begin
                    dec_digit = 1'b1;
                    dec_len = {{(LB-4){1'b0}}, d[3:0]};
                    dec_phase = P_DIGITS;
                end
                else if (!(c == " " || (c >= 8'h09 && c <= CR)))
                begin
                    dec_phase = P_REST;
                end
            end
            P_ZERO:
            begin
                if (c == "x" || c == "X") dec_phase = P_DIGITS;
                else if (d < 16) feed_nibble(d[3:0]);
                else dec_phase = P_REST;
            end
            P_DIGITS:
            begin
                if (d < 16) feed_nibble(d[3:0]);
                else dec_phase = P_REST;
            end
            default: ;
        endcase
        if (last) return close_stream(ERR_TRUNCATED, r);
        return 1'b0;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [LB-1:0] pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return LB'($urandom_range(1, 8));
        if (r < 97) return LB'($urandom_range(9, 64));
        return LB'($urandom_range(65, 300));
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 10) return 8'("0" + n);
        return 8'(($urandom_range(0, 1) ? "A" : "a") + n - 10);
    endfunction

    // append a line byte, never letting a CR be followed by LF by accident
    function automatic void put(input logic [7:0] b);
        if (pend.size() > 0 && pend[pend.size() - 1] == CR && b == LF) b = " ";
        pend.push_back(b);
    endfunction

    function automatic void add_blank();
        int n;
        n = ($urandom_range(0, 99) < 60) ? 0 : $urandom_range(1, 3);
        repeat (n) put(BLANKS[8 * $urandom_range(0, 5) +: 8]);
    endfunction

    // length in hex: plain, with 0x prefix, or with leading zeros
    function automatic void add_size(input logic [LB-1:0] len);
        int n;
        int form;
        n = 1;
        while (n < LB / 4 && (len >> (4 * n)) != 0) n++;
        form = $urandom_range(0, 3);
        if (form == 2)
        begin
            put("0");
            put($urandom_range(0, 1) ? "x" : "X");
        end
        if (form == 3) repeat ($urandom_range(1, 3)) put("0");
        for (int i = n - 1; i >= 0; i--) put(hex_char(len[4 * i +: 4]));
    endfunction

    // optional extension after the digits, then CR LF
    function automatic void add_tail();
        if ($urandom_range(0, 1))
        begin
            put(TAIL_STARTS[8 * $urandom_range(0, 6) +: 8]);
            repeat ($urandom_range(0, 6)) put(8'($urandom_range(0, 255)));
        end
        pend.push_back(CR);
        pend.push_back(LF);
    endfunction

    // offer one request and wait until it is taken
    task automatic push_byte(input logic [7:0] b, input logic last, input chk_t kind,
                             input logic [7:0] want);
        int gap;
        gap = (press || calm) ? 0 : pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tlast <= last;
        row_kind = kind;
        row_want = want;
        n_sent++;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic drain(input bit close);
        int k;
        k = pend.size();
        for (int i = 0; i < k; i++) push_byte(pend[i], close && (i == k - 1), CHK_PRED, 8'h00);
        pend.delete();
    endtask

    // size line, data and trailer of one chunk
    task automatic send_chunk(input logic [LB-1:0] len, input trail_t trail, input bit squeeze);
        logic [7:0] b;
        calm = ($urandom_range(0, 3) == 0);
        add_blank();
        add_size(len);
        add_tail();
        drain(1'b0);
        if (squeeze)
        begin
            press = 1'b1;
            stall_req = 1'b1;
        end
        repeat (len) pend.push_back(8'($urandom_range(0, 255)));
        drain(1'b0);
        press = 1'b0;
        case (trail)
            TR_PLAIN, TR_LAST:
            begin
                pend.push_back(CR);
                pend.push_back(LF);
                drain(trail == TR_LAST);
            end
            TR_CUT:
            begin
                pend.push_back($urandom_range(0, 1) ? CR : 8'($urandom_range(0, 255)));
                drain(1'b1);
            end
            default:
            begin
                if ($urandom_range(0, 1))
                begin
                    b = 8'($urandom_range(0, 255));
                    pend.push_back(b == CR ? "x" : b);
                end
                else
                begin
                    pend.push_back(CR);
                    b = 8'($urandom_range(0, 255));
                    pend.push_back(b == LF ? "y" : b);
                end
                drain(1'b0);
            end
        endcase
    endtask

    // result checking, request accounting and watchdog
    always @(posedge clk)
    begin : sampler
        decoded_t want;
        decoded_t pred;
        bit has_pred;
        if (rst_n)
        begin
            idle_cycles++;
            if (m_axis_tvalid && m_axis_tready)
            begin
                idle_cycles = 0;
                if (result_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with nothing expected, got tdata=%h tuser=%b tlast=%b",
                             $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                end
                else
                begin
                    want = result_q.pop_front();
                    if (want.payload) n_payload++;
                    if ({5'd0, want.code, want.data} !== m_axis_tdata ||
                        want.payload !== m_axis_tuser || want.done !== m_axis_tlast)
                    begin
                        errors++;
                        $display("%0t: mismatch, expected tdata=%h tuser=%b tlast=%b, got tdata=%h tuser=%b tlast=%b",
                                 $time, {5'd0, want.code, want.data}, want.payload, want.done,
                                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                idle_cycles = 0;
                n_bytes++;
                has_pred = decode_byte(s_axis_tdata, s_axis_tlast, pred);
                if (row_kind == CHK_DATA) result_q.push_back('{row_want, 1'b1, 1'b0, ERR_NONE});
                else if (row_kind == CHK_PRED && has_pred) result_q.push_back(pred);
            end
            if (idle_cycles >= WATCHDOG)
            begin
                $display("%0t: no request moved for %0d cycles", $time, WATCHDOG);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // receiver: random ready stretches and gaps, plus one long hold-off
    initial
    begin : sink
        int left;
        bit on;
        left = 0;
        on = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_req && !stall_done)
            begin
                stall_done = 1'b1;
                on = 1'b0;
                left = STALL_CYCLES;
            end
            else if (left == 0)
            begin
                on = !on;
                left = on ? $urandom_range(1, 40) : pick_gap();
                if (left == 0)
                begin
                    on = 1'b1;
                    left = $urandom_range(1, 40);
                end
            end
            m_axis_tready <= on;
            left--;
        end
    end

    initial
    begin : stimulus
        close_t how;
        logic [LB-1:0] big;
        bit squeezed;
        bit sq;
        squeezed = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed opening
        foreach (intro_rows[i])
            push_byte(intro_rows[i].b, 1'b0, intro_rows[i].kind, intro_rows[i].want);

        // random well-formed chunks, one of them under a long receiver hold-off
        while (n_sent < RANDOM_BYTES)
        begin
            sq = !squeezed && n_sent > 400;
            if (sq) squeezed = 1'b1;
            send_chunk(sq ? LB'(48) : pick_len(), TR_PLAIN, sq);
        end

        // close the stream one way, chosen per run
        how = close_t'($urandom_range(0, 8));
        case (how)
            END_ZERO:
            begin
                add_blank();
                add_size('0);
                add_tail();
                drain(1'($urandom_range(0, 1)));
            end
            END_AFTER_CRLF: send_chunk(pick_len(), TR_LAST, 1'b0);
            END_CUT_LINE:
            begin
                add_blank();
                if ($urandom_range(0, 1)) add_size(LB'($urandom));
                if ($urandom_range(0, 1))
                begin
                    put(";");
                    repeat ($urandom_range(0, 4)) put(8'($urandom_range(0, 255)));
                end
                if (pend.size() == 0) put("7");
                drain(1'b1);
            end
            END_CUT_SIZE:
            begin
                add_blank();
                add_size(pick_len());
                add_tail();
                drain(1'b1);
            end
            END_CUT_DATA:
            begin
                big = $urandom_range(0, 1) ? '1 : LB'($urandom | 32'h100);
                add_blank();
                add_size(big);
                add_tail();
                drain(1'b0);
                repeat ($urandom_range(1, 12)) pend.push_back(8'($urandom_range(0, 255)));
                drain(1'b1);
            end
            END_CUT_TRAIL: send_chunk(pick_len(), TR_CUT, 1'b0);
            END_BAD_TRAIL: send_chunk(pick_len(), TR_BAD, 1'b0);
            END_NO_DIGITS:
            begin
                add_blank();
                if ($urandom_range(0, 1))
                begin
                    put(NODIG_STARTS[8 * $urandom_range(0, 5) +: 8]);
                    repeat ($urandom_range(0, 5)) put(8'($urandom_range(0, 255)));
                end
                pend.push_back(CR);
                pend.push_back(LF);
                drain(1'($urandom_range(0, 1)));
            end
            default:
            begin
                add_blank();
                if ($urandom_range(0, 1))
                begin
                    put("0");
                    put("x");
                end
                put(hex_char(4'($urandom_range(1, 15))));
                repeat ($urandom_range(8, 12)) put(hex_char(4'($urandom_range(0, 15))));
                add_tail();
                drain(1'($urandom_range(0, 1)));
            end
        endcase

        // bytes after the close must be swallowed
        calm = 1'b0;
        repeat ($urandom_range(10, 30))
            push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), CHK_PRED, 8'h00);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;

        while (result_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("covered %0d encoded bytes, %0d chunks, %0d payload bytes checked",
                 n_bytes, n_chunks, n_payload);
        $display("stream closed by %s with code %0d after a %0d cycle receiver hold-off",
                 how.name(), last_code, STALL_CYCLES);
        if (errors == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/hcd_pkg.sv
rtl/hcd_in_reg.sv
rtl/hcd_core.sv
rtl/http_chunked_decoder.sv
sim/tb_top.sv
